FILE: rtl/pps_pkg.sv
// Shared constants, types and tables for the pointer precision scaler.
`default_nettype none
package pps_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_MAX         = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y    = 2'd2;

  localparam int SQRT_RAD_W  = 64;
  localparam int SQRT_ROOT_W = 32;
  localparam int SQRT_STAGES = SQRT_ROOT_W / 2;

  localparam int DIV_D_W    = 32;
  localparam int DIV_Q_W    = 31;
  localparam int DIV_STAGES = (DIV_Q_W + 1) / 2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               smooth;
  } item_t;

  function automatic int cordic_stages(input int steps);
    return (steps < ATAN_MAX) ? steps : ATAN_MAX;
  endfunction

  function automatic int pipe_latency(input int steps);
    return 11 + 2 * SQRT_STAGES + 2 * DIV_STAGES + cordic_stages(steps);
  endfunction

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'd843314856;
      1:       val = 32'd497837829;
      2:       val = 32'd263043836;
      3:       val = 32'd133525158;
      4:       val = 32'd67021686;
      5:       val = 32'd33543515;
      6:       val = 32'd16775850;
      7:       val = 32'd8388437;
      8:       val = 32'd4194282;
      9:       val = 32'd2097149;
      10:      val = 32'd1048575;
      11:      val = 32'd524287;
      12:      val = 32'd262143;
      13:      val = 32'd131071;
      14:      val = 32'd65535;
      15:      val = 32'd32767;
      16:      val = 32'd16383;
      17:      val = 32'd8191;
      18:      val = 32'd4095;
      19:      val = 32'd2047;
      20:      val = 32'd1023;
      21:      val = 32'd511;
      22:      val = 32'd255;
      23:      val = 32'd127;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pointer_precision_scaler.sv
// Top level of the pointer precision scaler: smoothing and speed pipeline.
//
// Use: pulse start with in_x / in_y (signed fixed point, FRAC_BITS fraction
// bits). A request is taken on any clock edge with start high and busy low;
// busy is high during reset and for the first cycle after it, so one request
// enters per cycle from then on.
// Each request yields one result, shown for one cycle with out_valid high:
// out_x / out_y (smoothed, speed-scaled, saturated), out_pos_x / out_pos_y
// (ceiling of the raw motion), out_smoothed and out_saturated.
// The path runs through two 16-stage square roots, two 16-stage dividers and
// one CORDIC stage per rotation. Throughput is one request per cycle,
// results in request order.
// Configuration: cfg_we with cfg_index and cfg_data writes threshold (0) or
// the x / y speed gains (1, 2); index 3 is ignored. Write only while idle.
// Reset clears every valid bit and loads threshold and gains with 1.0.
// The receiver cannot stall: a result is gone after its cycle.
`default_nettype none
module pointer_precision_scaler #(
  parameter int FRAC_BITS    = pps_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [31:0]              in_x,
  input  wire logic signed [31:0]              in_y,
  output logic                                 out_valid,
  output logic signed [31:0]                   out_x,
  output logic signed [31:0]                   out_y,
  output logic signed [15:0]                   out_pos_x,
  output logic signed [15:0]                   out_pos_y,
  output logic                                 out_smoothed,
  output logic                                 out_saturated,
  input  wire logic                            cfg_we,
  input  wire logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pps_pkg::*;

  localparam int NC = cordic_stages(CORDIC_STEPS);
  localparam logic [30:0] THR_ONE  = 31'(64'd1 << FRAC_BITS);
  localparam logic [23:0] GAIN_ONE = 24'(64'd1 << FRAC_BITS);
  localparam logic [24:0] GAIN_DEF = 25'(64'd1 << FRAC_BITS);
  localparam logic signed [32:0] CEIL_ADD  = 33'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [57:0] SCALE_RND = 58'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [63:0] SIN_RND   = 64'sd536870912;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd1073741824;

  typedef struct packed {
    item_t       item;
    logic [31:0] cy;
  } sq2_side_t;

  typedef struct packed {
    item_t item;
    logic  mag_zero;
  } dv2_side_t;

  function automatic logic signed [15:0] ceil_sat(input logic signed [31:0] v);
    logic signed [32:0] c;
    c = ($signed({v[31], v}) + CEIL_ADD) >>> FRAC_BITS;
    if (c > 33'sd32767) begin
      return 16'sh7FFF;
    end else if (c < -33'sd32768) begin
      return 16'sh8000;
    end
    return c[15:0];
  endfunction

  // configuration
  logic [30:0] thr_r;
  logic [23:0] gain_x_r;
  logic [23:0] gain_y_r;
  logic        busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_ONE;
      gain_x_r <= GAIN_ONE;
      gain_y_r <= GAIN_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r    <= cfg_data;
        REG_GAIN_X:    gain_x_r <= cfg_data[23:0];
        REG_GAIN_Y:    gain_y_r <= cfg_data[23:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // stage 1: capture, magnitudes
  logic               s1_vld_r;
  logic signed [31:0] s1_x_r, s1_y_r;
  logic [31:0]        s1_ax_r, s1_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r  <= in_x;
    s1_y_r  <= in_y;
    s1_ax_r <= in_x[31] ? 32'(-in_x) : in_x;
    s1_ay_r <= in_y[31] ? 32'(-in_y) : in_y;
  end

  // stage 2: squares, ceilings
  logic        s2_vld_r;
  item_t       s2_item_r;
  logic [63:0] s2_sqx_r, s2_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_item_r.x      <= s1_x_r;
    s2_item_r.y      <= s1_y_r;
    s2_item_r.pos_x  <= ceil_sat(s1_x_r);
    s2_item_r.pos_y  <= ceil_sat(s1_y_r);
    s2_item_r.smooth <= 1'b0;
    s2_sqx_r         <= 64'(s1_ax_r) * 64'(s1_ax_r);
    s2_sqy_r         <= 64'(s1_ay_r) * 64'(s1_ay_r);
  end

  // stage 3: sum of squares
  logic        s3_vld_r;
  item_t       s3_item_r;
  logic [63:0] s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_item_r <= s2_item_r;
    s3_sum_r  <= s2_sqx_r + s2_sqy_r;
  end

  // vector length
  logic        sq1_valid;
  logic [31:0] sq1_root;
  item_t       sq1_item;

  pps_isqrt #(.SIDE_W($bits(item_t))) u_len_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_rad    (s3_sum_r),
    .in_side   (s3_item_r),
    .out_valid (sq1_valid),
    .out_root  (sq1_root),
    .out_side  (sq1_item)
  );

  // stage 4: smoothing decision
  logic        s4_vld_r;
  item_t       s4_item_r;
  item_t       s4_item_nxt;
  logic [31:0] s4_len_r;

  always_comb begin
    s4_item_nxt        = sq1_item;
    s4_item_nxt.smooth = (thr_r != '0) && (sq1_root < {1'b0, thr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= sq1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_item_r <= s4_item_nxt;
    s4_len_r  <= sq1_root;
  end

  // angle = len / threshold in Q30
  logic        dv1_valid;
  logic [30:0] dv1_q;
  item_t       dv1_item;

  pps_div #(.SIDE_W($bits(item_t))) u_angle_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_vld_r),
    .in_hi     (s4_len_r),
    .in_d      ({1'b0, thr_r}),
    .in_side   (s4_item_r),
    .out_valid (dv1_valid),
    .out_q     (dv1_q),
    .out_side  (dv1_item)
  );

  // CORDIC rotation, one step per stage
  logic               cd_vld_r  [0:NC-1];
  logic signed [33:0] cd_x_r    [0:NC-1];
  logic signed [33:0] cd_y_r    [0:NC-1];
  logic signed [32:0] cd_z_r    [0:NC-1];
  item_t              cd_item_r [0:NC-1];

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic               v_in;
    logic signed [33:0] x_in, y_in, x_nxt, y_nxt;
    logic signed [32:0] z_in, z_nxt, a_step;
    item_t              item_in;

    if (i == 0) begin : g_first
      assign v_in    = dv1_valid;
      assign x_in    = CORDIC_X0;
      assign y_in    = '0;
      assign z_in    = $signed({2'b00, dv1_q});
      assign item_in = dv1_item;
    end else begin : g_next
      assign v_in    = cd_vld_r[i-1];
      assign x_in    = cd_x_r[i-1];
      assign y_in    = cd_y_r[i-1];
      assign z_in    = cd_z_r[i-1];
      assign item_in = cd_item_r[i-1];
    end

    assign a_step = $signed({1'b0, atan_q30(i)});

    always_comb begin
      if (!z_in[32]) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - a_step;
      end else begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + a_step;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_vld_r[i] <= 1'b0;
      end else begin
        cd_vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      cd_x_r[i]    <= x_nxt;
      cd_y_r[i]    <= y_nxt;
      cd_z_r[i]    <= z_nxt;
      cd_item_r[i] <= item_in;
    end
  end

  // stage 5: clamp and magnitudes of the CORDIC vector
  logic        s5_vld_r;
  item_t       s5_item_r;
  logic [31:0] s5_cy_r, s5_ux_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= cd_vld_r[NC-1];
    end
  end

  always_ff @(posedge clk) begin
    s5_item_r <= cd_item_r[NC-1];
    s5_cy_r   <= cd_y_r[NC-1][33] ? 32'd0 : cd_y_r[NC-1][31:0];
    s5_ux_r   <= cd_x_r[NC-1][33] ? 32'(-cd_x_r[NC-1]) : cd_x_r[NC-1][31:0];
  end

  // stage 6: squares for the gain removal
  logic        s6_vld_r;
  item_t       s6_item_r;
  logic [31:0] s6_cy_r;
  logic [63:0] s6_sqx_r, s6_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_item_r <= s5_item_r;
    s6_cy_r   <= s5_cy_r;
    s6_sqx_r  <= 64'(s5_ux_r) * 64'(s5_ux_r);
    s6_sqy_r  <= 64'(s5_cy_r) * 64'(s5_cy_r);
  end

  // stage 7: sum
  logic      s7_vld_r;
  sq2_side_t s7_side_r;
  logic [63:0] s7_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_side_r.item <= s6_item_r;
    s7_side_r.cy   <= s6_cy_r;
    s7_sum_r       <= s6_sqx_r + s6_sqy_r;
  end

  logic        sq2_valid;
  logic [31:0] sq2_root;
  sq2_side_t   sq2_side;

  pps_isqrt #(.SIDE_W($bits(sq2_side_t))) u_mag_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s7_vld_r),
    .in_rad    (s7_sum_r),
    .in_side   (s7_side_r),
    .out_valid (sq2_valid),
    .out_root  (sq2_root),
    .out_side  (sq2_side)
  );

  dv2_side_t dv2_in_side;
  logic      dv2_valid;
  logic [30:0] dv2_q;
  dv2_side_t dv2_side;

  assign dv2_in_side.item     = sq2_side.item;
  assign dv2_in_side.mag_zero = (sq2_root == '0);

  pps_div #(.SIDE_W($bits(dv2_side_t))) u_sine_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq2_valid),
    .in_hi     (sq2_side.cy),
    .in_d      (sq2_root),
    .in_side   (dv2_in_side),
    .out_valid (dv2_valid),
    .out_q     (dv2_q),
    .out_side  (dv2_side)
  );

  // stage 8: component times sine
  logic               s8_vld_r;
  item_t              s8_item_r;
  logic signed [63:0] s8_px_r, s8_py_r;
  logic [30:0]        sine;

  assign sine = dv2_side.mag_zero ? 31'd0 : dv2_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else begin
      s8_vld_r <= dv2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s8_item_r <= dv2_side.item;
    s8_px_r   <= dv2_side.item.x * $signed({1'b0, sine});
    s8_py_r   <= dv2_side.item.y * $signed({1'b0, sine});
  end

  // stage 9: round back, pick smoothed or raw
  logic               s9_vld_r;
  item_t              s9_item_r;
  logic signed [32:0] s9_vx_r, s9_vy_r;
  logic signed [63:0] sx_round, sy_round;

  assign sx_round = (s8_px_r + SIN_RND) >>> 30;
  assign sy_round = (s8_py_r + SIN_RND) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else begin
      s9_vld_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s9_item_r <= s8_item_r;
    s9_vx_r   <= s8_item_r.smooth ? sx_round[32:0] : 33'(s8_item_r.x);
    s9_vy_r   <= s8_item_r.smooth ? sy_round[32:0] : 33'(s8_item_r.y);
  end

  // stage 10: speed gain
  logic               s10_vld_r;
  item_t              s10_item_r;
  logic signed [57:0] s10_px_r, s10_py_r;
  logic [24:0]        gx, gy;

  assign gx = (gain_x_r == '0) ? GAIN_DEF : {1'b0, gain_x_r};
  assign gy = (gain_y_r == '0) ? GAIN_DEF : {1'b0, gain_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_vld_r <= 1'b0;
    end else begin
      s10_vld_r <= s9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s10_item_r <= s9_item_r;
    s10_px_r   <= s9_vx_r * $signed({1'b0, gx});
    s10_py_r   <= s9_vy_r * $signed({1'b0, gy});
  end

  // stage 11: round, saturate, drive the result
  logic signed [57:0] rx, ry;
  logic               fit_x, fit_y;
  logic               out_valid_r, out_smoothed_r, out_saturated_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic signed [15:0] out_pos_x_r, out_pos_y_r;

  assign rx    = (s10_px_r + SCALE_RND) >>> FRAC_BITS;
  assign ry    = (s10_py_r + SCALE_RND) >>> FRAC_BITS;
  assign fit_x = (rx[57:31] == {27{rx[57]}});
  assign fit_y = (ry[57:31] == {27{ry[57]}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s10_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r         <= fit_x ? rx[31:0] : (rx[57] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    out_y_r         <= fit_y ? ry[31:0] : (ry[57] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    out_pos_x_r     <= s10_item_r.pos_x;
    out_pos_y_r     <= s10_item_r.pos_y;
    out_smoothed_r  <= s10_item_r.smooth;
    out_saturated_r <= !fit_x || !fit_y;
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_pos_x     = out_pos_x_r;
  assign out_pos_y     = out_pos_y_r;
  assign out_smoothed  = out_smoothed_r;
  assign out_saturated = out_saturated_r;

endmodule
`default_nettype wire

FILE: rtl/pps_isqrt.sv
// Pipelined integer square root, two result bits per stage, with side data.
`default_nettype none
module pps_isqrt #(
  parameter int SIDE_W = 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic [pps_pkg::SQRT_RAD_W-1:0]  in_rad,
  input  wire logic [SIDE_W-1:0]                in_side,
  output logic                                  out_valid,
  output logic [pps_pkg::SQRT_ROOT_W-1:0]       out_root,
  output logic [SIDE_W-1:0]                     out_side
);
  import pps_pkg::*;

  localparam int NS   = SQRT_STAGES;
  localparam int RW   = SQRT_ROOT_W;
  localparam int RADW = SQRT_RAD_W;
  localparam int REMW = RW + 4;

  logic              vld_r  [0:NS-1];
  logic [RADW-1:0]   rad_r  [0:NS-1];
  logic [REMW-1:0]   rem_r  [0:NS-1];
  logic [RW-1:0]     root_r [0:NS-1];
  logic [SIDE_W-1:0] side_r [0:NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic              v_in;
    logic [RADW-1:0]   rad_in;
    logic [REMW-1:0]   rem_in;
    logic [RW-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic [RADW-1:0]   rad_nxt;
    logic [REMW-1:0]   rem_nxt;
    logic [RW-1:0]     root_nxt;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [REMW-1:0] trial;
      rad_nxt  = rad_in;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      trial    = '0;
      for (int t = 0; t < 2; t++) begin
        rem_nxt = {rem_nxt[REMW-3:0], rad_nxt[RADW-1 -: 2]};
        trial   = {{(REMW-RW-2){1'b0}}, root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[RW-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[RW-2:0], 1'b0};
        end
        rad_nxt = {rad_nxt[RADW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[s]  <= rad_nxt;
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire

FILE: rtl/pps_div.sv
// Pipelined restoring divider for (hi << 30) / d, hi below twice d, with side data.
`default_nettype none
module pps_div #(
  parameter int SIDE_W = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [pps_pkg::DIV_D_W-1:0]  in_hi,
  input  wire logic [pps_pkg::DIV_D_W-1:0]  in_d,
  input  wire logic [SIDE_W-1:0]            in_side,
  output logic                              out_valid,
  output logic [pps_pkg::DIV_Q_W-1:0]       out_q,
  output logic [SIDE_W-1:0]                 out_side
);
  import pps_pkg::*;

  localparam int NS = DIV_STAGES;
  localparam int DW = DIV_D_W;
  localparam int QW = DIV_Q_W;

  logic              vld_r  [0:NS-1];
  logic [DW-1:0]     rem_r  [0:NS-1];
  logic [DW-1:0]     d_r    [0:NS-1];
  logic [QW-1:0]     num_r  [0:NS-1];
  logic [QW-1:0]     q_r    [0:NS-1];
  logic [SIDE_W-1:0] side_r [0:NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic              v_in;
    logic [DW-1:0]     rem_in;
    logic [DW-1:0]     d_in;
    logic [QW-1:0]     num_in;
    logic [QW-1:0]     q_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW-1:0]     rem_nxt;
    logic [QW-1:0]     num_nxt;
    logic [QW-1:0]     q_nxt;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = {1'b0, in_hi[DW-1:1]};
      assign d_in    = in_d;
      assign num_in  = {in_hi[0], {(QW-1){1'b0}}};
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign d_in    = d_r[s-1];
      assign num_in  = num_r[s-1];
      assign q_in    = q_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [DW:0] rs;
      logic        qb;
      rem_nxt = rem_in;
      num_nxt = num_in;
      q_nxt   = q_in;
      rs      = '0;
      qb      = 1'b0;
      for (int t = 0; t < 2; t++) begin
        if (s * 2 + t < QW) begin
          rs = {rem_nxt, num_nxt[QW-1]};
          qb = (rs >= {1'b0, d_in});
          if (qb) begin
            rs = rs - {1'b0, d_in};
          end
          rem_nxt = rs[DW-1:0];
          q_nxt   = {q_nxt[QW-2:0], qb};
          num_nxt = {num_nxt[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      d_r[s]    <= d_in;
      num_r[s]  <= num_nxt;
      q_r[s]    <= q_nxt;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_q     = q_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire

FILE: rtl/pps_checker.sv
// Port-level checks for the pointer precision scaler, bound to the top level.
`default_nettype none
module pps_checker #(
  parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic signed [31:0] out_x,
  input wire logic signed [31:0] out_y,
  input wire logic               out_saturated
);
  import pps_pkg::*;

  localparam int LAT = pipe_latency(CORDIC_STEPS);

  a_reset_clears_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a request at the pipeline latency");

  a_saturation_clips: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_x == 32'sh7FFF_FFFF || out_x == 32'sh8000_0000 ||
       out_y == 32'sh7FFF_FFFF || out_y == 32'sh8000_0000))
    else $error("saturation flag without a clipped output");

endmodule

bind pointer_precision_scaler pps_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_pps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_x         (out_x),
  .out_y         (out_y),
  .out_saturated (out_saturated)
);
`default_nettype wire

FILE: tb/sv/tb_pointer_precision_scaler.sv
// Testbench for the pointer precision scaler: self-predicting, random and directed motions.
`timescale 1ns / 100ps
module tb_pointer_precision_scaler;
  import pps_pkg::*;

  localparam int LATENCY = 91;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               smooth;
    logic               sat;
  } motion_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic signed [31:0] in_x = 0, in_y = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  wire busy, out_valid, out_smoothed, out_saturated;
  wire signed [31:0] out_x, out_y;
  wire signed [15:0] out_pos_x, out_pos_y;

  pointer_precision_scaler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_x(in_x), .in_y(in_y),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y), .out_smoothed(out_smoothed), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  logic [30:0] threshold_q;
  logic [23:0] gain_x_q, gain_y_q;
  motion_t pending_motions[$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int smoothed_seen = 0;
  int saturated_seen = 0;
  bit quiet = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint sine_q30(input longint angle);
    longint cx, cy, z, dx, dy;
    logic [63:0] ux, mag;
    cx = 64'sd1 << 30;
    cy = 0;
    z = angle;
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= longint'(atan_q30(i));
      end else begin
        cx += dx; cy -= dy; z += longint'(atan_q30(i));
      end
    end
    if (cy < 0) cy = 0;
    ux = (cx < 0) ? -cx : cx;
    mag = isqrt(ux * ux + cy * cy);
    if (mag == 0) return 0;
    return longint'((64'(cy) << 30) / mag);
  endfunction

  function automatic logic signed [15:0] ceil_int(input longint v);
    longint c;
    c = (v + 65535) >>> 16;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return c[15:0];
  endfunction

  function automatic logic signed [31:0] apply_gain(input longint v, input logic [23:0] g,
                                                    inout logic sat);
    longint gg, p;
    gg = (g == 0) ? 65536 : longint'(g);
    p = (v * gg + 32768) >>> 16;
    if (p > 64'sd2147483647) begin
      p = 64'sd2147483647; sat = 1;
    end
    if (p < -64'sd2147483648) begin
      p = -64'sd2147483648; sat = 1;
    end
    return p[31:0];
  endfunction

  function automatic motion_t predict_motion(input logic signed [31:0] ix,
                                             input logic signed [31:0] iy);
    motion_t m;
    longint x, y, s, r;
    logic [63:0] ax, ay, len;
    x = ix;
    y = iy;
    m.px = ceil_int(x);
    m.py = ceil_int(y);
    m.smooth = 0;
    m.sat = 0;
    if (threshold_q != 0) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      len = isqrt(ax * ax + ay * ay);
      if (len < threshold_q) begin
        r = longint'((len << 30) / threshold_q);
        s = sine_q30(r);
        x = (x * s + (64'sd1 << 29)) >>> 30;
        y = (y * s + (64'sd1 << 29)) >>> 30;
        m.smooth = 1;
      end
    end
    m.x = apply_gain(x, gain_x_q, m.sat);
    m.y = apply_gain(y, gain_y_q, m.sat);
    return m;
  endfunction

  always @(posedge clk) begin
    motion_t e;
    if (out_valid) begin
      results_seen++;
      if (pending_motions.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_motions.pop_front();
        if (out_x !== e.x) begin
          $error("out_x expected %0d got %0d", e.x, out_x); errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %0d got %0d", e.y, out_y); errors++;
        end
        if (out_pos_x !== e.px) begin
          $error("out_pos_x expected %0d got %0d", e.px, out_pos_x); errors++;
        end
        if (out_pos_y !== e.py) begin
          $error("out_pos_y expected %0d got %0d", e.py, out_pos_y); errors++;
        end
        if (out_smoothed !== e.smooth) begin
          $error("out_smoothed expected %0d got %0d", e.smooth, out_smoothed); errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("out_saturated expected %0d got %0d", e.sat, out_saturated); errors++;
        end
        smoothed_seen += e.smooth;
        saturated_seen += e.sat;
      end
    end
  end

  task automatic send_motion(input logic signed [31:0] x, input logic signed [31:0] y);
    while (!quiet && $urandom_range(99) < 23) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_x <= x;
    in_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_motions.push_back(predict_motion(x, y));
    requests_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_THRESHOLD: threshold_q = val;
      REG_GAIN_X:    gain_x_q = val[23:0];
      REG_GAIN_Y:    gain_y_q = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain;
    start <= 0;
    while (pending_motions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(input logic [30:0] thr);
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(2 * 65536)) - 65536;
      2: return $signed($urandom_range(32'h7fff_ffff)) >>> $urandom_range(31);
      3: return (thr == 0) ? $urandom : $signed(32'($urandom_range(thr))) >>> 1;
      4: return -($signed($urandom_range(32'h7fff_ffff)) >>> $urandom_range(31));
      default: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  task automatic test_directed_edges;
    send_motion(0, 0);
    send_motion(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_motion(32'sh8000_0000, 32'sh8000_0000);
    send_motion(32'sh7fff_ffff, 32'sh8000_0000);
    send_motion(65536, 0);
    send_motion(-65536, 0);
    send_motion(1, -1);
    send_motion(32768, 32768);
    send_motion(-32768, 20000);
    send_motion(65535, -65535);
    send_motion(32'sh0000_ffff, 32'shffff_0001);
    drain();
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_GAIN_X, 24'hff_ffff);
    write_reg(REG_GAIN_Y, 0);
    send_motion(32'sh7fff_ffff, 32'sh8000_0000);
    send_motion(32'sh8000_0000, 32'sh7fff_ffff);
    send_motion(0, 0);
    send_motion(65536, -65536);
    drain();
    write_reg(REG_THRESHOLD, 31'h7fff_ffff);
    write_reg(REG_GAIN_X, 0);
    write_reg(REG_GAIN_Y, 24'hff_ffff);
    write_reg(3, 31'h1234);
    send_motion(0, 0);
    send_motion(32'sh7fff_ffff, 0);
    send_motion(-1000000, 123456789);
    send_motion(32'sh4000_0000, 32'shc000_0000);
    drain();
  endtask

  task automatic test_random_phases;
    logic [30:0] thr;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: thr = $urandom_range(4 * 65536);
        1: thr = $urandom;
        2: thr = 0;
        default: thr = $urandom_range(65536 * 64);
      endcase
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_GAIN_X, (ph == 3) ? 0 : $urandom_range(24'hff_ffff) >> $urandom_range(23));
      write_reg(REG_GAIN_Y, (ph == 5) ? 24'hff_ffff : $urandom_range(24'h3_ffff));
      quiet = (ph == 6);
      for (int i = 0; i < 150; i++) send_motion(rand_coord(thr), rand_coord(thr));
      quiet = 0;
      drain();
    end
  endtask

  initial begin
    threshold_q = 31'd65536;
    gain_x_q = 24'd65536;
    gain_y_q = 24'd65536;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed_edges();
    test_random_phases();
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d motion requests over 13 register settings; %0d results checked.",
             requests_sent, results_seen);
    $display("Smoothed results: %0d, saturated results: %0d.", smoothed_seen, saturated_seen);
    if (errors == 0 && pending_motions.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
